@@ src/mbsf_pkg.sv @@
// Shared types, function codes and mask helper for the mono bitmap span filler.
package mbsf_pkg;

    localparam logic [1:0] FUNC_FILL  = 2'd0;
    localparam logic [1:0] FUNC_BEGIN = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    localparam logic [7:0] FULL_MASK = 8'hFF;
    localparam logic [7:0] NO_MASK   = 8'h00;
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [7:0] mask;
        logic [3:0] cnt;
        logic       last;
    } span_step_t;

    // Mask of cnt pixels starting at pixel off of a byte, pixel 0 in the MSB.
    function automatic logic [7:0] span_mask(input logic [2:0] off, input logic [3:0] cnt);
        logic [8:0] ones;
        logic [3:0] sh;
        ones = (9'd1 << cnt) - 9'd1;
        sh   = BYTE_BITS - {1'b0, off} - cnt;
        return ones[7:0] << sh;
    endfunction

endpackage

@@ src/mono_bitmap_span_fill_core.sv @@
// Top level of the one-bit-per-pixel span filler: command intake, sequencer, write output.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  cmd     | in        | cmd_valid, cmd_ready | func, pixel_value, run_length
//  wr      | out       | wr_valid, wr_ready   | buffer_index, byte_address, bit_mask,
//          |           |                      | write_value, last
//
// A fill command of nonzero length L starting at pixel offset o produces ceil((o + L) / 8)
// byte writes (at most 33 for a 255-pixel run), one per cycle while the output register is
// not stalled; the block takes no new command until the run is done. Begin-frame, end-frame,
// the unused code and a zero-length fill complete at the command transfer. The span-step
// unit handles one byte per cycle and sets this rate.
// Reset clears the pixel position, selects buffer A and empties the output register.
// A stalled write holds the sequencer; the next command can be taken while the final
// write of the previous run still waits in the output register.
module mono_bitmap_span_fill_core #(
    parameter int BUFFER_BYTES = 65536,
    parameter int MAX_RUN      = 255
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  func,
    input  logic        pixel_value,
    input  logic [7:0]  run_length,

    output logic        wr_valid,
    input  logic        wr_ready,
    output logic        buffer_index,
    output logic [15:0] byte_address,
    output logic [7:0]  bit_mask,
    output logic        write_value,
    output logic        last
);

    localparam int ByteW       = $clog2(BUFFER_BYTES);
    localparam int PosW        = ByteW + 3;
    localparam int TotalPixels = BUFFER_BYTES * 8;
    // Run lengths arrive as 8 bits, so a cap of 255 or more never bites.
    localparam int RunCap      = (MAX_RUN < 255) ? MAX_RUN : 255;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic            state_reg, state_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [7:0]      rem_reg, rem_next;
    logic            colour_reg, colour_next;
    logic            buf_reg, buf_next;

    logic            wr_valid_reg, wr_valid_next;
    logic            buf_out_reg, buf_out_next;
    logic [15:0]     addr_reg, addr_next;
    logic [7:0]      mask_reg, mask_next;
    logic            value_reg, value_next;
    logic            last_reg, last_next;

    mbsf_pkg::span_step_t step;
    logic [PosW-1:0]      step_pos;
    logic [7:0]           run_clamped;
    logic [ByteW-1:0]     byte_idx;
    logic                 out_free;
    logic                 cmd_xfer;

    mbsf_span_step #(
        .PosW        (PosW),
        .TotalPixels (TotalPixels)
    ) u_step (
        .pos      (pos_reg),
        .rem      (rem_reg),
        .step     (step),
        .next_pos (step_pos)
    );

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign cmd_xfer    = cmd_valid && cmd_ready;
    assign out_free    = !wr_valid_reg || wr_ready;
    assign run_clamped = (run_length > 8'(RunCap)) ? 8'(RunCap) : run_length;
    assign byte_idx    = pos_reg[PosW-1:3];

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        colour_next   = colour_reg;
        buf_next      = buf_reg;
        wr_valid_next = wr_valid_reg && !wr_ready;
        buf_out_next  = buf_out_reg;
        addr_next     = addr_reg;
        mask_next     = mask_reg;
        value_next    = value_reg;
        last_next     = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    unique case (func)
                        mbsf_pkg::FUNC_FILL:
                        begin
                            rem_next    = run_clamped;
                            colour_next = pixel_value;
                            if (run_clamped != 8'd0)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                        mbsf_pkg::FUNC_BEGIN:
                        begin
                            pos_next = '0;
                        end
                        mbsf_pkg::FUNC_END:
                        begin
                            buf_next = !buf_reg;
                        end
                        default:
                        begin
                            // The unused code is dropped without effect.
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                // One byte write per cycle whenever the output register can take it.
                if (out_free)
                begin
                    wr_valid_next = 1'b1;
                    buf_out_next  = buf_reg;
                    addr_next     = 16'(byte_idx);
                    mask_next     = step.mask;
                    value_next    = colour_reg;
                    last_next     = step.last;
                    pos_next      = step_pos;
                    rem_next      = rem_reg - {4'd0, step.cnt};
                    if (step.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            buf_reg      <= 1'b0;
            wr_valid_reg <= 1'b0;
            rem_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            buf_reg      <= buf_next;
            wr_valid_reg <= wr_valid_next;
            rem_reg      <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg  <= colour_next;
        buf_out_reg <= buf_out_next;
        addr_reg    <= addr_next;
        mask_reg    <= mask_next;
        value_reg   <= value_next;
        last_reg    <= last_next;
    end

    assign wr_valid     = wr_valid_reg;
    assign buffer_index = buf_out_reg;
    assign byte_address = addr_reg;
    assign bit_mask     = mask_reg;
    assign write_value  = value_reg;
    assign last         = last_reg;

    // The position never reaches the end of the buffer; wrapping happens in the step unit.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < (PosW + 1)'(TotalPixels))
        else $error("pixel position beyond buffer end");

    // While a run is in progress there are always pixels left to draw.
    a_run_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rem_reg != 8'd0))
        else $error("run state with no pixels left");

    // A write that is held back keeps its valid and its fields until it is transferred.
    a_wr_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_valid_reg && !wr_ready) |=> (wr_valid_reg &&
            $stable({buf_out_reg, addr_reg, mask_reg, value_reg, last_reg})))
        else $error("stalled write changed before its transfer");

endmodule

@@ src/mbsf_span_step.sv @@
// One step of the span walk: mask, pixel count and next position for one byte.
module mbsf_span_step #(
    parameter int PosW        = 19,
    parameter int TotalPixels = 524288
) (
    input  logic [PosW-1:0]          pos,
    input  logic [7:0]               rem,
    output mbsf_pkg::span_step_t     step,
    output logic [PosW-1:0]          next_pos
);

    logic [2:0]    off;
    logic [3:0]    avail;
    logic [3:0]    cnt;
    logic [PosW:0] sum;

    always_comb
    begin
        off   = pos[2:0];
        avail = mbsf_pkg::BYTE_BITS - {1'b0, off};
        cnt   = (rem < {4'd0, avail}) ? rem[3:0] : avail;
        sum   = {1'b0, pos} + {{(PosW - 3){1'b0}}, cnt};
        // The position stays below the buffer size, so one subtract wraps it.
        if (sum >= (PosW + 1)'(TotalPixels))
        begin
            sum = sum - (PosW + 1)'(TotalPixels);
        end
        next_pos  = sum[PosW-1:0];
        step.cnt  = cnt;
        step.mask = (cnt == 4'd0) ? mbsf_pkg::NO_MASK : mbsf_pkg::span_mask(off, cnt);
        step.last = (rem == {4'd0, cnt});
    end

endmodule

@@ test/mono_bitmap_span_fill_core_tb.sv @@
// Self-checking testbench for the one-bit-per-pixel span filler core.
module mono_bitmap_span_fill_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Function code with no meaning to the block; it must be swallowed silently.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Runs longer than this are cut short by the block.
    localparam int RUN_CAP = 255;

    // Percentage of cycles in which each side holds back.
    localparam int IDLE_PCT = 24;

    // Cycles allowed after the last expected write for stray writes to show up.
    localparam int DRAIN_CYCLES = 40;

    // About 110 commands, with random stalls on both sides, must finish within this limit.
    localparam int CYCLE_LIMIT = 40000;

    // Random commands run with neither side idling, then with both sides idling.
    localparam int STEADY_CMDS = 30;
    localparam int RANDOM_CMDS = 60;

    typedef struct packed {
        logic [1:0] func;
        logic       pixel_value;
        logic [7:0] run_length;
    } draw_cmd_t;

    typedef struct packed {
        logic        buffer_index;
        logic [15:0] byte_address;
        logic [7:0]  bit_mask;
        logic        write_value;
        logic        last;
    } byte_write_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [1:0]  func;
    logic        pixel_value;
    logic [7:0]  run_length;
    logic        wr_valid;
    logic        wr_ready;
    logic        buffer_index;
    logic [15:0] byte_address;
    logic [7:0]  bit_mask;
    logic        write_value;
    logic        last;

    // Commands not yet presented, and byte writes predicted but not yet seen.
    draw_cmd_t   cmd_pending[$];
    byte_write_t writes_due[$];

    // The predictor's copy of the block state: next pixel to draw and current back buffer.
    logic [18:0] draw_pos;
    logic        draw_buf;

    // While set, neither side idles, so the block runs at full rate.
    logic        steady;

    int          mismatch_count;
    int          cycle_count;
    draw_cmd_t   next_cmd;
    byte_write_t seen_write;
    byte_write_t due_write;

    mono_bitmap_span_fill_core uut (.*);

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Advance the drawing state by one accepted command and queue the byte writes that it
    // causes. Pixel 0 of a byte sits in the MSB, so a span of cnt pixels starting at
    // offset off covers the bits between (0xFF >> off) and (0xFF >> (off + cnt)).
    task automatic predict_span_writes(input draw_cmd_t c);
        int          left;
        int          off;
        int          cnt;
        byte_write_t w;
        case (c.func)
            mbsf_pkg::FUNC_BEGIN: draw_pos = '0;
            mbsf_pkg::FUNC_END:   draw_buf = ~draw_buf;
            mbsf_pkg::FUNC_FILL:
            begin
                left = c.run_length;
                if (left > RUN_CAP)
                    left = RUN_CAP;
                while (left > 0)
                begin
                    off = draw_pos[2:0];
                    cnt = 8 - off;
                    if (cnt > left)
                        cnt = left;
                    left -= cnt;
                    w.buffer_index = draw_buf;
                    w.byte_address = draw_pos[18:3];
                    w.bit_mask     = 8'((255 >> off) & ~(255 >> (off + cnt)));
                    w.write_value  = c.pixel_value;
                    w.last         = (left == 0);
                    writes_due.push_back(w);
                    // The position register is exactly one buffer of pixels wide, so
                    // the wrap at buffer end falls out of the 19-bit add.
                    draw_pos = draw_pos + 19'(cnt);
                end
            end
            default: ;
        endcase
    endtask

    function automatic draw_cmd_t make_cmd(input logic [1:0] f, input logic v,
                                           input logic [7:0] len);
        draw_cmd_t c;
        c.func        = f;
        c.pixel_value = v;
        c.run_length  = len;
        return c;
    endfunction

    // Random command mix: mostly fills, with short runs favored so that partial bytes
    // and the byte boundaries come up often, and some full-length runs for the long path.
    function automatic draw_cmd_t random_cmd();
        int       pick;
        int       len_pick;
        logic [7:0] len;
        pick     = $urandom_range(99);
        len_pick = $urandom_range(99);
        if (len_pick < 50)
            len = 8'($urandom_range(16));
        else if (len_pick < 85)
            len = 8'($urandom_range(255));
        else
            len = 8'($urandom_range(255, 248));
        if (pick < 80)
            return make_cmd(mbsf_pkg::FUNC_FILL, 1'($urandom_range(1)), len);
        else if (pick < 88)
            return make_cmd(mbsf_pkg::FUNC_BEGIN, 1'($urandom_range(1)), len);
        else if (pick < 96)
            return make_cmd(mbsf_pkg::FUNC_END, 1'($urandom_range(1)), len);
        else
            return make_cmd(FUNC_UNUSED, 1'($urandom_range(1)), len);
    endfunction

    // Block until every queued command has been transferred and every predicted write has
    // come out of the block.
    task automatic wait_until_quiet();
        do
            @(posedge clk);
        while (cmd_pending.size() != 0 || cmd_valid || writes_due.size() != 0);
    endtask

    // Command driver. The handshake is sampled with the values that were on the wires
    // before this edge, so an accepted command is predicted exactly as the block saw it.
    // A new command is loaded only when the channel is empty or the present one has just
    // been transferred, which keeps valid and payload steady while the block stalls.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                predict_span_writes(make_cmd(func, pixel_value, run_length));
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_cmd    = cmd_pending.pop_front();
                    cmd_valid   <= 1'b1;
                    func        <= next_cmd.func;
                    pixel_value <= next_cmd.pixel_value;
                    run_length  <= next_cmd.run_length;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Write monitor. Each transferred write is checked field by field against the oldest
    // prediction; the receiver then decides afresh whether to stall the next cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_valid && wr_ready)
            begin
                seen_write = {buffer_index, byte_address, bit_mask, write_value, last};
                if (writes_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected write buf %0d addr %h mask %h",
                                              buffer_index, byte_address, bit_mask));
                end
                else
                begin
                    due_write = writes_due.pop_front();
                    if (seen_write.buffer_index !== due_write.buffer_index)
                        report_mismatch($sformatf("buffer_index %0d, expected %0d",
                            seen_write.buffer_index, due_write.buffer_index));
                    if (seen_write.byte_address !== due_write.byte_address)
                        report_mismatch($sformatf("byte_address %h, expected %h",
                            seen_write.byte_address, due_write.byte_address));
                    if (seen_write.bit_mask !== due_write.bit_mask)
                        report_mismatch($sformatf("bit_mask %h, expected %h at addr %h",
                            seen_write.bit_mask, due_write.bit_mask, due_write.byte_address));
                    if (seen_write.write_value !== due_write.write_value)
                        report_mismatch($sformatf("write_value %0d, expected %0d",
                            seen_write.write_value, due_write.write_value));
                    if (seen_write.last !== due_write.last)
                        report_mismatch($sformatf("last %0d, expected %0d at addr %h",
                            seen_write.last, due_write.last, due_write.byte_address));
                end
            end
            wr_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        func           = mbsf_pkg::FUNC_FILL;
        pixel_value    = 1'b0;
        run_length     = '0;
        wr_ready       = 1'b0;
        steady         = 1'b0;
        draw_pos       = '0;
        draw_buf       = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A zero-length fill must emit nothing, then partial bytes of
        // growing width walk the offset through the first byte. A full byte lands
        // aligned and a full-length run starts on a byte boundary. After a frame restart
        // a seven-pixel fill leaves the position on the last pixel of a byte, so the
        // full-length run that follows touches the most bytes.
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd0));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd1));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b0, 8'd3));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd4));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd8));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b0, 8'd255));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_END, 1'b1, 8'd255));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd12));
        // The unused code carries a live-looking payload and must change nothing.
        cmd_pending.push_back(make_cmd(FUNC_UNUSED, 1'b1, 8'd200));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b0, 8'd2));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_BEGIN, 1'b0, 8'd17));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd7));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b0, 8'd255));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_END, 1'b0, 8'd0));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b0, 8'd128));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd127));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_END, 1'b1, 8'd1));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_BEGIN, 1'b1, 8'd0));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b1, 8'd255));
        cmd_pending.push_back(make_cmd(mbsf_pkg::FUNC_FILL, 1'b0, 8'd9));
        cmd_pending.push_back(make_cmd(FUNC_UNUSED, 1'b0, 8'd0));
        wait_until_quiet();

        // Random commands with neither side idling, so the block runs back to back.
        steady = 1'b1;
        for (int i = 0; i < STEADY_CMDS; i++)
            cmd_pending.push_back(random_cmd());
        wait_until_quiet();
        steady = 1'b0;

        // Random part, with both sides idling at random.
        for (int i = 0; i < RANDOM_CMDS; i++)
            cmd_pending.push_back(random_cmd());
        wait_until_quiet();

        // Give the block time to show any write that was never predicted.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ mono_bitmap_span_fill_core.f @@
src/mbsf_pkg.sv
src/mbsf_span_step.sv
src/mono_bitmap_span_fill_core.sv
test/mono_bitmap_span_fill_core_tb.sv
